>>> hdl/qst_pkg.sv
// Shared types and constants for the quaternion/scale to transform pipeline.
package qst_pkg;

  // Field and intermediate widths
  localparam int QW        = 16;  // Q2.14 quaternion component
  localparam int SW        = 16;  // Q8.8 scale
  localparam int PW        = 32;  // Q16.16 position and results
  localparam int PROD_W    = 33;  // doubled product, Q5.28
  localparam int SUM_W     = 34;  // sum or difference of two doubled products
  localparam int WIDE_W    = SUM_W + SW;  // entry times scale, Q.36
  localparam int FRAC_DROP = 20;  // Q.36 down to Q16.16

  // Constant one in Q6.28
  localparam logic signed [SUM_W-1:0] ONE_Q = SUM_W'(34'sd268435456);
  // Half an output LSB for round to nearest, ties up
  localparam logic signed [WIDE_W-1:0] HALF_LSB = WIDE_W'(50'sd524288);
  // Saturation bounds of a 32-bit result
  localparam logic signed [WIDE_W-1:0] RES_MAX = WIDE_W'(50'sd2147483647);
  localparam logic signed [WIDE_W-1:0] RES_MIN = -WIDE_W'(50'sd2147483648);

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
    logic signed [QW-1:0] w;
  } quat_t;

  typedef struct packed {
    logic signed [SW-1:0] x;
    logic signed [SW-1:0] y;
    logic signed [SW-1:0] z;
  } scale_t;

  typedef struct packed {
    logic [PW-1:0] x;
    logic [PW-1:0] y;
    logic [PW-1:0] z;
  } pos_t;

  // Input item
  typedef struct packed {
    quat_t  quat;
    scale_t scale;
    pos_t   pos;
  } in_t;

  // After the product stage
  typedef struct packed {
    logic signed [PROD_W-1:0] xx;
    logic signed [PROD_W-1:0] xy;
    logic signed [PROD_W-1:0] xz;
    logic signed [PROD_W-1:0] yy;
    logic signed [PROD_W-1:0] yz;
    logic signed [PROD_W-1:0] zz;
    logic signed [PROD_W-1:0] wx;
    logic signed [PROD_W-1:0] wy;
    logic signed [PROD_W-1:0] wz;
    scale_t scale;
    pos_t   pos;
  } prod_t;

  // Rotation entries before scaling, Q6.28
  typedef struct packed {
    logic signed [SUM_W-1:0] r0c0, r1c0, r2c0;
    logic signed [SUM_W-1:0] r0c1, r1c1, r2c1;
    logic signed [SUM_W-1:0] r0c2, r1c2, r2c2;
  } mat_sum_t;

  typedef struct packed {
    mat_sum_t m;
    scale_t   scale;
    pos_t     pos;
  } comb_t;

  // Scaled entries, Q.36
  typedef struct packed {
    logic signed [WIDE_W-1:0] r0c0, r1c0, r2c0;
    logic signed [WIDE_W-1:0] r0c1, r1c1, r2c1;
    logic signed [WIDE_W-1:0] r0c2, r1c2, r2c2;
  } mat_wide_t;

  typedef struct packed {
    mat_wide_t m;
    pos_t      pos;
  } wide_t;

  // Final entries, Q16.16
  typedef struct packed {
    logic signed [PW-1:0] r0c0, r1c0, r2c0;
    logic signed [PW-1:0] r0c1, r1c1, r2c1;
    logic signed [PW-1:0] r0c2, r1c2, r2c2;
  } mat_out_t;

  typedef struct packed {
    mat_out_t m;
    pos_t     pos;
  } out_t;

endpackage

>>> hdl/quaternion_scale_to_transform.sv
// Top level: quaternion, scale and position to a scaled 3x4 TRS transform.
//
// Input stream (s_*): one transfer carries a Q2.14 quaternion, a Q8.8 scale
// per axis and a Q16.16 position. Output stream (m_*): one transfer carries
// the nine scaled rotation entries and the translation, all Q16.16.
// Every input transfer yields exactly one output transfer, in order.
//
// Four register stages: doubled products, sums/differences, column scaling
// by the 34x16 multipliers, then rounding/saturation into the output
// register. The sustained rate is one transfer per cycle while m_tready
// stays high.
// Each stage carries its own valid bit and loads whenever it is empty or
// the stage after it moves, so bubbles are squeezed out and an input is
// still taken while a finished result waits at the output. When m_tready
// is low with every stage full, s_tready drops and nothing is lost or
// repeated. Synchronous reset empties all stages; s_tready is high after.
module quaternion_scale_to_transform (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // quat_x, quat_y, quat_z, quat_w, scale_x, scale_y, scale_z, pos_x, pos_y, pos_z
  input  logic [207:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_r0c0, m_r1c0, m_r2c0, m_r0c1, m_r1c1, m_r2c1, m_r0c2, m_r1c2, m_r2c2,
  // trans_x, trans_y, trans_z
  output logic [383:0] m_tdata
);
  import qst_pkg::*;

  in_t   in_item;
  prod_t prod_item;
  comb_t comb_item;
  wide_t wide_item;
  out_t  out_item;

  logic prod_valid, prod_ready;
  logic comb_valid, comb_ready;
  logic wide_valid, wide_ready;

  // Unpack input transfer
  always_comb begin
    in_item.quat.x  = s_tdata[15:0];
    in_item.quat.y  = s_tdata[31:16];
    in_item.quat.z  = s_tdata[47:32];
    in_item.quat.w  = s_tdata[63:48];
    in_item.scale.x = s_tdata[79:64];
    in_item.scale.y = s_tdata[95:80];
    in_item.scale.z = s_tdata[111:96];
    in_item.pos.x   = s_tdata[143:112];
    in_item.pos.y   = s_tdata[175:144];
    in_item.pos.z   = s_tdata[207:176];
  end

  qst_prod u_prod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_item  (prod_item)
  );

  qst_comb u_comb (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_item   (prod_item),
    .out_valid (comb_valid),
    .out_ready (comb_ready),
    .out_item  (comb_item)
  );

  qst_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (comb_valid),
    .in_ready  (comb_ready),
    .in_item   (comb_item),
    .out_valid (wide_valid),
    .out_ready (wide_ready),
    .out_item  (wide_item)
  );

  qst_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (wide_valid),
    .in_ready  (wide_ready),
    .in_item   (wide_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  // Pack output transfer
  assign m_tdata = {out_item.pos.z, out_item.pos.y, out_item.pos.x,
                    out_item.m.r2c2, out_item.m.r1c2, out_item.m.r0c2,
                    out_item.m.r2c1, out_item.m.r1c1, out_item.m.r0c1,
                    out_item.m.r2c0, out_item.m.r1c0, out_item.m.r0c0};

endmodule

>>> hdl/qst_prod.sv
// Stage 1: doubled quaternion cross products.
module qst_prod (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  qst_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output qst_pkg::prod_t out_item
);
  import qst_pkg::*;

  // 2*a*b, exact
  function automatic logic signed [PROD_W-1:0] dbl_mul(input logic signed [QW-1:0] a,
                                                       input logic signed [QW-1:0] b);
    logic signed [2*QW-1:0] p;
    p = a * b;
    return {p, 1'b0};
  endfunction

  logic  valid;
  prod_t item_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  // Product terms
  always_comb begin
    item_next.xx    = dbl_mul(in_item.quat.x, in_item.quat.x);
    item_next.xy    = dbl_mul(in_item.quat.x, in_item.quat.y);
    item_next.xz    = dbl_mul(in_item.quat.x, in_item.quat.z);
    item_next.yy    = dbl_mul(in_item.quat.y, in_item.quat.y);
    item_next.yz    = dbl_mul(in_item.quat.y, in_item.quat.z);
    item_next.zz    = dbl_mul(in_item.quat.z, in_item.quat.z);
    item_next.wx    = dbl_mul(in_item.quat.w, in_item.quat.x);
    item_next.wy    = dbl_mul(in_item.quat.w, in_item.quat.y);
    item_next.wz    = dbl_mul(in_item.quat.w, in_item.quat.z);
    item_next.scale = in_item.scale;
    item_next.pos   = in_item.pos;
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

>>> hdl/qst_comb.sv
// Stage 2: sums and differences forming the unscaled rotation entries.
module qst_comb (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  qst_pkg::prod_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output qst_pkg::comb_t out_item
);
  import qst_pkg::*;

  // Sign-extend a doubled product to sum width
  function automatic logic signed [SUM_W-1:0] ext(input logic signed [PROD_W-1:0] a);
    return {a[PROD_W-1], a};
  endfunction

  logic  valid;
  comb_t item_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  // Rotation matrix entries
  always_comb begin
    item_next.m.r0c0 = ONE_Q - (ext(in_item.yy) + ext(in_item.zz));
    item_next.m.r1c0 = ext(in_item.xy) + ext(in_item.wz);
    item_next.m.r2c0 = ext(in_item.xz) - ext(in_item.wy);
    item_next.m.r0c1 = ext(in_item.xy) - ext(in_item.wz);
    item_next.m.r1c1 = ONE_Q - (ext(in_item.xx) + ext(in_item.zz));
    item_next.m.r2c1 = ext(in_item.yz) + ext(in_item.wx);
    item_next.m.r0c2 = ext(in_item.xz) + ext(in_item.wy);
    item_next.m.r1c2 = ext(in_item.yz) - ext(in_item.wx);
    item_next.m.r2c2 = ONE_Q - (ext(in_item.xx) + ext(in_item.yy));
    item_next.scale  = in_item.scale;
    item_next.pos    = in_item.pos;
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

>>> hdl/qst_scale.sv
// Stage 3: multiply each matrix column by its axis scale.
module qst_scale (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  qst_pkg::comb_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output qst_pkg::wide_t out_item
);
  import qst_pkg::*;

  // Exact entry times scale
  function automatic logic signed [WIDE_W-1:0] mul_s(input logic signed [SUM_W-1:0] e,
                                                     input logic signed [SW-1:0] s);
    logic signed [WIDE_W-1:0] p;
    p = e * s;
    return p;
  endfunction

  logic  valid;
  wide_t item_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  // Column scaling
  always_comb begin
    item_next.m.r0c0 = mul_s(in_item.m.r0c0, in_item.scale.x);
    item_next.m.r1c0 = mul_s(in_item.m.r1c0, in_item.scale.x);
    item_next.m.r2c0 = mul_s(in_item.m.r2c0, in_item.scale.x);
    item_next.m.r0c1 = mul_s(in_item.m.r0c1, in_item.scale.y);
    item_next.m.r1c1 = mul_s(in_item.m.r1c1, in_item.scale.y);
    item_next.m.r2c1 = mul_s(in_item.m.r2c1, in_item.scale.y);
    item_next.m.r0c2 = mul_s(in_item.m.r0c2, in_item.scale.z);
    item_next.m.r1c2 = mul_s(in_item.m.r1c2, in_item.scale.z);
    item_next.m.r2c2 = mul_s(in_item.m.r2c2, in_item.scale.z);
    item_next.pos    = in_item.pos;
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

>>> hdl/qst_round.sv
// Stage 4: round to Q16.16, saturate, hold the output register.
module qst_round (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  qst_pkg::wide_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output qst_pkg::out_t  out_item
);
  import qst_pkg::*;

  // Round to nearest, ties toward plus infinity, then clamp
  function automatic logic signed [PW-1:0] to_q16(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] t;
    logic signed [WIDE_W-1:0] q;
    logic signed [PW-1:0]     r;
    t = v + HALF_LSB;
    q = t >>> FRAC_DROP;
    if (q > RES_MAX) begin
      r = RES_MAX[PW-1:0];
    end else if (q < RES_MIN) begin
      r = RES_MIN[PW-1:0];
    end else begin
      r = q[PW-1:0];
    end
    return r;
  endfunction

  logic valid;
  out_t item_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_comb begin
    item_next.m.r0c0 = to_q16(in_item.m.r0c0);
    item_next.m.r1c0 = to_q16(in_item.m.r1c0);
    item_next.m.r2c0 = to_q16(in_item.m.r2c0);
    item_next.m.r0c1 = to_q16(in_item.m.r0c1);
    item_next.m.r1c1 = to_q16(in_item.m.r1c1);
    item_next.m.r2c1 = to_q16(in_item.m.r2c1);
    item_next.m.r0c2 = to_q16(in_item.m.r0c2);
    item_next.m.r1c2 = to_q16(in_item.m.r1c2);
    item_next.m.r2c2 = to_q16(in_item.m.r2c2);
    item_next.pos    = in_item.pos;
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

>>> test/quaternion_scale_to_transform_test.sv
// Self-checking stream testbench for the quaternion/scale to 3x4 transform block.
`timescale 1ns / 100ps

module quaternion_scale_to_transform_test;

  // One input transfer, quat_x in the lowest bits
  typedef struct packed {
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
    logic signed [15:0] scale_z;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_x;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_x;
  } pose_t;

  // One output transfer, m_r0c0 in the lowest bits
  typedef struct packed {
    logic [31:0] trans_z;
    logic [31:0] trans_y;
    logic [31:0] trans_x;
    logic [31:0] m_r2c2;
    logic [31:0] m_r1c2;
    logic [31:0] m_r0c2;
    logic [31:0] m_r2c1;
    logic [31:0] m_r1c1;
    logic [31:0] m_r0c1;
    logic [31:0] m_r2c0;
    logic [31:0] m_r1c0;
    logic [31:0] m_r0c0;
  } xform_t;

  localparam int    NUM_FIELDS = 12;
  localparam longint SAT_MAX   = 64'sd2147483647;
  localparam longint SAT_MIN   = -64'sd2147483648;
  localparam int    HOLD_CYCLES = 300;
  localparam int    DRAIN_CYCLES = 12;

  // Names for mismatch reports, index i is bits [32*i +: 32]
  localparam string FIELD_NAMES [NUM_FIELDS] = '{
    "m_r0c0", "m_r1c0", "m_r2c0", "m_r0c1", "m_r1c1", "m_r2c1",
    "m_r0c2", "m_r1c2", "m_r2c2", "trans_x", "trans_y", "trans_z"};

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // quat_x, quat_y, quat_z, quat_w, scale_x, scale_y, scale_z, pos_x, pos_y, pos_z
  logic [207:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // m_r0c0, m_r1c0, m_r2c0, m_r0c1, m_r1c1, m_r2c1, m_r0c2, m_r1c2, m_r2c2,
  // trans_x, trans_y, trans_z
  logic [383:0] m_tdata;

  pose_t  pending_poses [$];
  xform_t expected_xforms [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          recv_hold = 1'b0;
  int unsigned mismatches = 0;
  int unsigned poses_sent = 0;
  int unsigned xforms_checked = 0;
  event        hold_go;

  quaternion_scale_to_transform u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Q.36 down to Q16.16: round to nearest, ties toward +inf, then saturate
  function automatic logic [31:0] q36_to_q16(longint v);
    longint q;
    q = (v + (longint'(1) <<< 19)) >>> 20;
    if (q > SAT_MAX) q = SAT_MAX;
    else if (q < SAT_MIN) q = SAT_MIN;
    return q[31:0];
  endfunction

  // Expected transform for one pose: doubled products, columns times scale
  function automatic xform_t trs_matrix(pose_t p);
    longint x, y, z, w, sx, sy, sz, one;
    longint xx, xy, xz, yy, yz, zz, wx, wy, wz;
    xform_t r;
    x = p.quat_x;  y = p.quat_y;  z = p.quat_z;  w = p.quat_w;
    sx = p.scale_x;  sy = p.scale_y;  sz = p.scale_z;
    one = longint'(1) <<< 28;
    xx = x * 2 * x;  xy = x * 2 * y;  xz = x * 2 * z;
    yy = y * 2 * y;  yz = y * 2 * z;  zz = z * 2 * z;
    wx = w * 2 * x;  wy = w * 2 * y;  wz = w * 2 * z;
    r.m_r0c0 = q36_to_q16((one - (yy + zz)) * sx);
    r.m_r1c0 = q36_to_q16((xy + wz) * sx);
    r.m_r2c0 = q36_to_q16((xz - wy) * sx);
    r.m_r0c1 = q36_to_q16((xy - wz) * sy);
    r.m_r1c1 = q36_to_q16((one - (xx + zz)) * sy);
    r.m_r2c1 = q36_to_q16((yz + wx) * sy);
    r.m_r0c2 = q36_to_q16((xz + wy) * sz);
    r.m_r1c2 = q36_to_q16((yz - wx) * sz);
    r.m_r2c2 = q36_to_q16((one - (xx + yy)) * sz);
    r.trans_x = p.pos_x;
    r.trans_y = p.pos_y;
    r.trans_z = p.pos_z;
    return r;
  endfunction

  function automatic pose_t make_pose(int qx, int qy, int qz, int qw,
                                      int sx, int sy, int sz,
                                      int px, int py, int pz);
    pose_t p;
    p.quat_x = 16'(qx);  p.quat_y = 16'(qy);  p.quat_z = 16'(qz);  p.quat_w = 16'(qw);
    p.scale_x = 16'(sx);  p.scale_y = 16'(sy);  p.scale_z = 16'(sz);
    p.pos_x = px;  p.pos_y = py;  p.pos_z = pz;
    return p;
  endfunction

  // Mostly near-unit rotations with modest scale; the rest raw random bits
  function automatic pose_t random_pose();
    pose_t p;
    real a, b, c, d, n;
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 16'($urandom)};
    if ($urandom_range(99) < 70) begin
      a = real'($urandom_range(65535)) - 32768.0;
      b = real'($urandom_range(65535)) - 32768.0;
      c = real'($urandom_range(65535)) - 32768.0;
      d = real'($urandom_range(65535)) - 32768.0;
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) n = 1.0;
      p.quat_x = 16'($rtoi(a * 16384.0 / n));
      p.quat_y = 16'($rtoi(b * 16384.0 / n));
      p.quat_z = 16'($rtoi(c * 16384.0 / n));
      p.quat_w = 16'($rtoi(d * 16384.0 / n));
      p.scale_x = 16'(int'($urandom_range(2048)) - 1024);
      p.scale_y = 16'(int'($urandom_range(2048)) - 1024);
      p.scale_z = 16'(int'($urandom_range(2048)) - 1024);
    end
    return p;
  endfunction

  // Input side: hold data until taken, then offer the next pending pose
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_xforms.push_back(trs_matrix(pose_t'(s_tdata)));
        poses_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_poses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tdata  <= pending_poses.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: random backpressure, compare each transfer with the oldest expectation
  always @(posedge clk) begin
    xform_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_xforms.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: output transfer with nothing expected, data %h", m_tdata);
        end else begin
          want = expected_xforms.pop_front();
          xforms_checked++;
          for (int i = 0; i < NUM_FIELDS; i++) begin
            if (m_tdata[32*i +: 32] !== want[32*i +: 32]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("ERROR: result %0d %s expected %h got %h", xforms_checked,
                         FIELD_NAMES[i], want[32*i +: 32], m_tdata[32*i +: 32]);
            end
          end
        end
      end
      m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver hold-off so the pipeline fills and s_tready drops
  initial begin
    @(hold_go);
    recv_hold = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    recv_hold = 1'b0;
  end

  // Wait until every queued pose has gone in and every result has come back
  task automatic drain();
    while (pending_poses.size() != 0 || s_tvalid || expected_xforms.size() != 0)
      @(negedge clk);
  endtask

  task automatic queue_random(int unsigned count);
    repeat (count) pending_poses.push_back(random_pose());
  endtask

  // Stimulus: directed corners, then three random phases with different idling
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // identity, zero quaternion, extremes of every field
    pending_poses.push_back(make_pose(0, 0, 0, 16384, 256, 256, 256, 0, 0, 0));
    pending_poses.push_back(make_pose(0, 0, 0, 0, 256, -256, 1, 1, -1, 65536));
    pending_poses.push_back(make_pose(32767, 32767, 32767, 32767, 32767, 32767, 32767,
                                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    pending_poses.push_back(make_pose(-32768, -32768, -32768, -32768,
                                      -32768, -32768, -32768,
                                      32'h80000000, 32'h80000000, 32'h80000000));
    pending_poses.push_back(make_pose(32767, -32768, 32767, -32768, 32767, -32768, 0,
                                      32'hffffffff, 0, 32'h80000000));
    pending_poses.push_back(make_pose(-32768, 0, 0, 32767, -32768, 32767, -32768,
                                      32'h12345678, 32'hdeadbeef, 32'h7fffffff));
    pending_poses.push_back(make_pose(0, -32768, 32767, 0, 32767, 32767, -32768,
                                      0, 32'h80000000, 32'h00000001));
    // quarter turns about each axis
    pending_poses.push_back(make_pose(11585, 0, 0, 11585, 256, 512, 768, 100, 200, 300));
    pending_poses.push_back(make_pose(0, 11585, 0, 11585, -256, 256, 128, 0, 0, 0));
    pending_poses.push_back(make_pose(0, 0, 11585, -11585, 1024, -1024, 256, 0, 0, 0));
    // half turn about x, and a quaternion of twice unit length (no normalization)
    pending_poses.push_back(make_pose(16384, 0, 0, 0, 256, 256, 256, 0, 0, 0));
    pending_poses.push_back(make_pose(0, 0, 0, 32767, 256, 256, 256, 0, 0, 0));
    pending_poses.push_back(make_pose(16384, 16384, 16384, 16384, 300, -300, 700, 5, 6, 7));
    // rounding ties: r1c0 lands exactly on +half, r0c1 exactly on -half
    pending_poses.push_back(make_pose(1, 16, 0, 0, 16384, -16384, 1, 0, 0, 0));
    pending_poses.push_back(make_pose(-1, 16, 0, 0, -16384, 16384, -1, 0, 0, 0));
    // tiny components and a scale of zero
    pending_poses.push_back(make_pose(1, -1, 1, -1, 0, 1, -1, 0, 0, 0));
    drain();

    // sender rarely idles, receiver mostly stalls
    send_idle_pct = 8;
    recv_idle_pct = 88;
    queue_random(300);
    drain();

    // sender mostly idles, receiver rarely stalls
    send_idle_pct = 88;
    recv_idle_pct = 8;
    queue_random(300);
    drain();

    // no idling, with one long output hold-off while the sender keeps offering
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(330);
    -> hold_go;
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_xforms.size() != 0) begin
      mismatches += expected_xforms.size();
      $display("ERROR: %0d results never arrived", expected_xforms.size());
    end
    $display("Covered %0d poses and checked %0d transforms: corners, rounding ties,",
             poses_sent, xforms_checked);
    $display("random rotations under input gaps, output stalls and a long hold-off.");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("ERROR: timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> quaternion_scale_to_transform.f
hdl/qst_pkg.sv
hdl/qst_prod.sv
hdl/qst_comb.sv
hdl/qst_scale.sv
hdl/qst_round.sv
hdl/quaternion_scale_to_transform.sv
test/quaternion_scale_to_transform_test.sv
